FILE: hdl/sncp_pkg.sv
`timescale 1ns / 1ps

package sncp_pkg;

	localparam int FRAC_BITS = 16;
	localparam int COORD_W   = 32;

	// Shared divider: quotient bits, dividend width, signed result width
	localparam int DIV_QB = 34;
	localparam int DIV_NW = 64;
	localparam int DIV_OW = DIV_QB + 2;

	typedef enum logic [1:0] {
		REG_ORIGIN_X      = 2'd0,
		REG_ORIGIN_Y      = 2'd1,
		REG_FOCAL_LENGTH  = 2'd2,
		REG_NEAR_DISTANCE = 2'd3
	} cfg_reg_t;

	// Segment state riding alongside the divider
	typedef struct packed {
		logic                       pass;
		logic                       clip;
		logic                       a_mv;
		logic signed [COORD_W-1:0]  ax;
		logic signed [COORD_W-1:0]  ay;
		logic signed [COORD_W-1:0]  az;
		logic signed [COORD_W-1:0]  bx;
		logic signed [COORD_W-1:0]  by;
		logic signed [COORD_W-1:0]  bz;
	} sncp_seg_t;

endpackage

FILE: hdl/sncp_div.sv
`timescale 1ns / 1ps

// Pipelined rounding divider: one quotient bit per stage.
// Result = sign * round_half_away(mag / den), clamped to all ones on overflow.
module sncp_div (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  logic                                vld_i,
	input  logic [sncp_pkg::DIV_NW-1:0]         mag_i,
	input  logic                                neg_i,
	input  logic [sncp_pkg::DIV_QB-1:0]         den_i,
	input  sncp_pkg::sncp_seg_t                 side_i,
	output logic                                vld_o,
	output logic signed [sncp_pkg::DIV_OW-1:0]  quo_o,
	output sncp_pkg::sncp_seg_t                 side_o
);
	import sncp_pkg::*;

	logic [DIV_NW-1:0] n0;
	logic              ovf0;

	logic              vld_p  [0:DIV_QB];
	logic [DIV_QB-1:0] rem_p  [0:DIV_QB];
	logic [DIV_QB-1:0] lo_p   [0:DIV_QB];
	logic [DIV_QB-1:0] quo_p  [0:DIV_QB];
	logic [DIV_QB-1:0] den_p  [0:DIV_QB];
	logic              neg_p  [0:DIV_QB];
	logic              zero_p [0:DIV_QB];
	logic              ovf_p  [0:DIV_QB];
	sncp_seg_t         side_p [0:DIV_QB];

	logic [DIV_QB-1:0] res;

	// half divisor added up front gives round to nearest
	assign n0   = mag_i + DIV_NW'(den_i >> 1);
	assign ovf0 = DIV_QB'(n0[DIV_NW-1:DIV_QB]) >= den_i;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_p[0] <= 1'b0;
		end else if (en) begin
			vld_p[0] <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_p[0]  <= DIV_QB'(n0[DIV_NW-1:DIV_QB]);
			lo_p[0]   <= n0[DIV_QB-1:0];
			quo_p[0]  <= '0;
			den_p[0]  <= den_i;
			neg_p[0]  <= neg_i;
			zero_p[0] <= (mag_i == '0);
			ovf_p[0]  <= ovf0;
			side_p[0] <= side_i;
		end
	end

	for (genvar k = 1; k <= DIV_QB; k++) begin : g_step
		logic [DIV_QB:0] r2;
		logic [DIV_QB:0] diff;
		logic            ge;

		assign r2   = {rem_p[k-1], lo_p[k-1][DIV_QB-1]};
		assign diff = r2 - {1'b0, den_p[k-1]};
		assign ge   = r2 >= {1'b0, den_p[k-1]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_p[k] <= 1'b0;
			end else if (en) begin
				vld_p[k] <= vld_p[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_p[k]  <= ge ? diff[DIV_QB-1:0] : r2[DIV_QB-1:0];
				lo_p[k]   <= {lo_p[k-1][DIV_QB-2:0], 1'b0};
				quo_p[k]  <= {quo_p[k-1][DIV_QB-2:0], ge};
				den_p[k]  <= den_p[k-1];
				neg_p[k]  <= neg_p[k-1];
				zero_p[k] <= zero_p[k-1];
				ovf_p[k]  <= ovf_p[k-1];
				side_p[k] <= side_p[k-1];
			end
		end
	end

	assign res = zero_p[DIV_QB] ? '0 : (ovf_p[DIV_QB] ? '1 : quo_p[DIV_QB]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_o <= 1'b0;
		end else if (en) begin
			vld_o <= vld_p[DIV_QB];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			quo_o  <= neg_p[DIV_QB] ? -$signed({2'b00, res}) : $signed({2'b00, res});
			side_o <= side_p[DIV_QB];
		end
	end

endmodule

FILE: hdl/segment_near_clip_project_unit.sv
`timescale 1ns / 1ps

// Near-plane clip and perspective projection of camera-space line segments.
// Input channel: in_valid/in_stall with both endpoints (x, y, z), signed Q16.16.
// Output channel: out_valid/out_stall with both screen points, saturated Q16.16.
// A segment wholly at or in front of z = -near_distance yields no output item.
// Otherwise an endpoint in front of the plane is pulled onto it, then both
// endpoints are divided by -z, scaled by focal_length and offset to the origin
// (screen y flipped).
// Throughput: one item per clock while out_stall does not hold the pipeline.
// The path runs through 36-stage dividers with one quotient bit per stage: one
// for the clip factor, then four in parallel for the projection.
// The pipeline moves as one: when out_valid is high and out_stall is high,
// every stage holds and in_stall is raised in the same cycle; nothing is lost.
// Reset (arst_n low) empties the pipeline and loads the default viewport
// registers. The config port writes one register per cycle with cfg_we; write
// only while no item is in flight.
module segment_near_clip_project_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] start_cam_x,
	input  logic signed [31:0] start_cam_y,
	input  logic signed [31:0] start_cam_z,
	input  logic signed [31:0] end_cam_x,
	input  logic signed [31:0] end_cam_y,
	input  logic signed [31:0] end_cam_z,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] start_screen_x,
	output logic signed [31:0] start_screen_y,
	output logic signed [31:0] end_screen_x,
	output logic signed [31:0] end_screen_y
);
	import sncp_pkg::*;

	localparam int PW  = 33 + FRAC_BITS + 2;   // lerp product width
	localparam int SW  = DIV_OW + 1;           // screen sum width

	// config registers
	logic signed [31:0] origin_x_q;
	logic signed [31:0] origin_y_q;
	logic [30:0]        focal_q;
	logic [30:0]        near_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q <= 32'sd20971520;
			origin_y_q <= 32'sd15728640;
			focal_q    <= 31'd26214400;
			near_q     <= 31'd65536;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_ORIGIN_X:      origin_x_q <= cfg_data;
				REG_ORIGIN_Y:      origin_y_q <= cfg_data;
				REG_FOCAL_LENGTH:  focal_q    <= cfg_data[30:0];
				REG_NEAR_DISTANCE: near_q     <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	// whole pipeline advances unless the output item is held
	logic adv;
	assign adv      = !(out_valid && out_stall);
	assign in_stall = !adv;

	function automatic logic signed [31:0] sat32(input logic signed [SW-1:0] v);
		if (v > SW'(64'sh7FFFFFFF))
			return 32'sh7FFFFFFF;
		else if (v < -SW'(64'sh80000000))
			return 32'sh80000000;
		else
			return v[31:0];
	endfunction

	// ---- s1: input register ----
	logic      v_s1;
	sncp_seg_t seg_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			seg_s1.ax   <= start_cam_x;
			seg_s1.ay   <= start_cam_y;
			seg_s1.az   <= start_cam_z;
			seg_s1.bx   <= end_cam_x;
			seg_s1.by   <= end_cam_y;
			seg_s1.bz   <= end_cam_z;
			seg_s1.pass <= 1'b0;
			seg_s1.clip <= 1'b0;
			seg_s1.a_mv <= 1'b0;
		end
	end

	// classify against the plane and set up the clip factor division
	logic signed [32:0] plane;
	logic signed [32:0] az33, bz33, zk33, zm33, pdiff, dz;
	logic               a_front, b_front;
	sncp_seg_t          seg_d;
	logic [DIV_NW-1:0]  t_mag;
	logic [DIV_QB-1:0]  t_den;

	always_comb begin
		plane   = -$signed({2'b00, near_q});
		az33    = 33'(seg_s1.az);
		bz33    = 33'(seg_s1.bz);
		a_front = az33 > plane;
		b_front = bz33 > plane;
		zk33    = a_front ? bz33 : az33;
		zm33    = a_front ? az33 : bz33;
		pdiff   = plane - zk33;
		dz      = zm33 - zk33;
		seg_d      = seg_s1;
		seg_d.pass = !(az33 >= plane && bz33 >= plane);
		seg_d.clip = a_front || b_front;
		seg_d.a_mv = a_front;
		if (seg_d.clip && seg_d.pass) begin
			t_mag = DIV_NW'(pdiff[31:0]) << FRAC_BITS;
			t_den = {1'b0, dz};
		end else begin
			t_mag = '0;
			t_den = DIV_QB'(1);
		end
	end

	logic                     tv;
	logic signed [DIV_OW-1:0] tq;
	sncp_seg_t                tseg;

	sncp_div u_tdiv (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.vld_i  (v_s1),
		.mag_i  (t_mag),
		.neg_i  (1'b0),
		.den_i  (t_den),
		.side_i (seg_d),
		.vld_o  (tv),
		.quo_o  (tq),
		.side_o (tseg)
	);

	// ---- s2: (move - keep) * t ----
	logic [FRAC_BITS:0]  t_u;
	logic signed [32:0]  dx, dy;
	logic                v_s2;
	logic signed [PW-1:0] prodx_s2, prody_s2;
	sncp_seg_t           seg_s2;

	assign t_u = tq[FRAC_BITS:0];
	assign dx  = tseg.a_mv ? 33'(tseg.ax) - 33'(tseg.bx) : 33'(tseg.bx) - 33'(tseg.ax);
	assign dy  = tseg.a_mv ? 33'(tseg.ay) - 33'(tseg.by) : 33'(tseg.by) - 33'(tseg.ay);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= tv;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prodx_s2 <= PW'(dx) * PW'($signed({1'b0, t_u}));
			prody_s2 <= PW'(dy) * PW'($signed({1'b0, t_u}));
			seg_s2   <= tseg;
		end
	end

	// ---- s3: round product, finish the moved endpoint ----
	logic [PW-1:0]      magx, magy, rndx, rndy;
	logic signed [32:0] kx, ky, delx, dely;
	logic [31:0]        newx, newy;
	sncp_seg_t          seg_c;
	logic               v_s3;
	sncp_seg_t          seg_s3;

	always_comb begin
		magx = prodx_s2[PW-1] ? PW'(-prodx_s2) : PW'(prodx_s2);
		magy = prody_s2[PW-1] ? PW'(-prody_s2) : PW'(prody_s2);
		rndx = (magx + (PW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
		rndy = (magy + (PW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
		delx = prodx_s2[PW-1] ? -$signed(rndx[32:0]) : $signed(rndx[32:0]);
		dely = prody_s2[PW-1] ? -$signed(rndy[32:0]) : $signed(rndy[32:0]);
		kx   = seg_s2.a_mv ? 33'(seg_s2.bx) : 33'(seg_s2.ax);
		ky   = seg_s2.a_mv ? 33'(seg_s2.by) : 33'(seg_s2.ay);
		newx = 32'(kx + delx);
		newy = 32'(ky + dely);
		seg_c = seg_s2;
		if (seg_s2.clip && seg_s2.pass) begin
			if (seg_s2.a_mv) begin
				seg_c.ax = newx;
				seg_c.ay = newy;
				seg_c.az = -$signed({1'b0, near_q});
			end else begin
				seg_c.bx = newx;
				seg_c.by = newy;
				seg_c.bz = -$signed({1'b0, near_q});
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			seg_s3 <= seg_c;
		end
	end

	// ---- s4: focal * coordinate, depth = -z ----
	// lanes: 0 start x, 1 start y, 2 end x, 3 end y
	logic signed [63:0]  num_s4 [0:3];
	logic [DIV_QB-1:0]   den_s4 [0:3];
	logic                v_s4;
	logic                pass_s4;
	logic signed [31:0]  lane_c [0:3];
	logic signed [31:0]  lane_z [0:3];

	assign lane_c[0] = seg_s3.ax;
	assign lane_c[1] = seg_s3.ay;
	assign lane_c[2] = seg_s3.bx;
	assign lane_c[3] = seg_s3.by;
	assign lane_z[0] = seg_s3.az;
	assign lane_z[1] = seg_s3.az;
	assign lane_z[2] = seg_s3.bz;
	assign lane_z[3] = seg_s3.bz;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pass_s4 <= seg_s3.pass;
			for (int i = 0; i < 4; i++) begin
				num_s4[i] <= 64'($signed({1'b0, focal_q})) * 64'(lane_c[i]);
				den_s4[i] <= DIV_QB'(-(33'(lane_z[i])));
			end
		end
	end

	// ---- projection dividers ----
	logic                     pv   [0:3];
	logic signed [DIV_OW-1:0] pq   [0:3];
	sncp_seg_t                pseg [0:3];
	sncp_seg_t                pside_in;

	always_comb begin
		pside_in      = '0;
		pside_in.pass = pass_s4;
	end

	for (genvar g = 0; g < 4; g++) begin : g_proj
		logic [DIV_NW-1:0] pmag;

		assign pmag = num_s4[g][63] ? DIV_NW'(-num_s4[g]) : DIV_NW'(num_s4[g]);

		sncp_div u_pdiv (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (adv),
			.vld_i  (v_s4),
			.mag_i  (pmag),
			.neg_i  (num_s4[g][63]),
			.den_i  (den_s4[g]),
			.side_i (pside_in),
			.vld_o  (pv[g]),
			.quo_o  (pq[g]),
			.side_o (pseg[g])
		);
	end

	// ---- s5: origin offset, saturate, output register ----
	logic signed [SW-1:0] sum_sx, sum_sy, sum_ex, sum_ey;

	assign sum_sx = SW'(origin_x_q) + SW'(pq[0]);
	assign sum_sy = SW'(origin_y_q) - SW'(pq[1]);
	assign sum_ex = SW'(origin_x_q) + SW'(pq[2]);
	assign sum_ey = SW'(origin_y_q) - SW'(pq[3]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= pv[0] && pseg[0].pass;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			start_screen_x <= sat32(sum_sx);
			start_screen_y <= sat32(sum_sy);
			end_screen_x   <= sat32(sum_ex);
			end_screen_y   <= sat32(sum_ey);
		end
	end

	// ---- checks ----
	// clip factor lies in [0, 1] for a segment that is clipped
	a_t_range: assert property (@(posedge clk) disable iff (!arst_n)
		(tv && tseg.clip && tseg.pass) |-> (tq >= 0 && tq <= (DIV_OW'(1) << FRAC_BITS)))
		else $error("clip factor out of range");

	// the four projection lanes stay in lockstep
	a_lanes: assert property (@(posedge clk) disable iff (!arst_n)
		(pv[0] == pv[1]) && (pv[1] == pv[2]) && (pv[2] == pv[3]))
		else $error("projection lanes out of step");

	// a moved endpoint sits exactly on the near plane
	a_on_plane: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && seg_s2.clip && seg_s2.pass && adv) |=>
		(seg_s3.a_mv ? seg_s3.az == -$signed({1'b0, near_q})
		             : seg_s3.bz == -$signed({1'b0, near_q})))
		else $error("moved endpoint off near plane");

endmodule
